@@ hw/rtl/rgb_error_diffusion_dither_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dither unit
// Short property wrappers used by the top level.
// ---------------------------------------------------------------------------
`ifndef RGB_ERROR_DIFFUSION_DITHER_UNIT_MACROS_SVH
`define RGB_ERROR_DIFFUSION_DITHER_UNIT_MACROS_SVH

// Implication checked on every edge outside reset.
`define RED_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RED_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/red_pkg.sv @@
// ---------------------------------------------------------------------------
// Dither unit package
// Shared types, register indexes and arithmetic helpers.
// ---------------------------------------------------------------------------
package red_pkg;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_QUANT,
        ST_WB0, ST_WB1, ST_WB2, ST_WB3, ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pix;

    // One channel of one neighbour update: floor((16p+w*e)/16) clamped.
    function automatic logic [7:0] red_spread(input logic [7:0] p,
                                              input logic signed [9:0] e,
                                              input logic [2:0] w);
        logic signed [14:0] n;
        n = $signed({3'b000, p, 4'b0000}) + $signed({1'b0, w}) * e;
        if (n < 0) n = '0;
        n = n >>> 4;
        if (n > 15'sd255) n = 15'sd255;
        return n[7:0];
    endfunction
endpackage

@@ hw/rtl/red_quant.sv @@
// ---------------------------------------------------------------------------
// Channel quantizer
// Computes q = floor(idx*255/m) with idx = floor((v*m+127)/255), iteratively.
// ---------------------------------------------------------------------------
module red_quant (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_v,
    input  logic [7:0] i_m,
    output logic       o_done,
    output logic [7:0] o_q
);
    // Phase 0: divide (v*m+127) by 255 (constant, reciprocal form).
    // Phase 1: restoring division of idx*255 by m, one bit per cycle.
    logic [15:0] r_num;
    logic [7:0]  r_den;
    logic [7:0]  r_rem;
    logic [7:0]  r_quo;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_t;
    logic [7:0]  w_idx;
    logic [8:0]  w_trial;

    always_comb begin
        w_t = {9'd0, i_v} * {9'd0, i_m} + 17'd127;
        // floor(t/255) for t < 65536: t*257>>16 with one correction
        w_idx = 8'(({8'd0, w_t} * 25'd257) >> 16);
        if ((w_t - 17'(w_idx) * 17'd255) >= 17'd255) w_idx = w_idx + 8'd1;
        w_trial = {r_rem, r_num[15]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= 16'({8'd0, w_idx} * 16'd255);
                r_den  <= i_m;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[14:0], 1'b0};
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= 8'(w_trial - {1'b0, r_den});
                    r_quo <= {r_quo[6:0], 1'b1};
                end else begin
                    r_rem <= w_trial[7:0];
                    r_quo <= {r_quo[6:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    // quotient fits in 8 bits; only its low byte is kept
    assign o_q = r_quo;
endmodule

@@ hw/rtl/rgb_error_diffusion_dither_unit.sv @@
// ---------------------------------------------------------------------------
// RGB error diffusion dither unit
// Floyd-Steinberg dithering of a raster pixel stream to a set level count.
// ---------------------------------------------------------------------------
// Usage: pixels enter on the s_axis channel in raster order; tuser bit 0 set
// marks a drain word. Each pixel word is stored in a ring memory of
// MAX_WIDTH+2 entries. Once width+1 pixels are ahead, the oldest pixel is
// quantized and its error spread to four neighbours; the result word leaves on
// m_axis with tlast marking the last pixel of the frame. After the frame is
// in, one drain word per remaining pixel flushes the buffer.
// A word that yields a result goes through reads of the pixel and its four
// neighbours, three quantizer runs (the divide by the level step takes one
// quotient bit per cycle), four write-backs and the output state before it
// shows up on m_axis. The next word is taken once the unit is back in idle.
// Words that yield no result are taken one per cycle while no configuration
// write is pending. One word is in work at a time.
// Reset returns registers to 640x480, two levels, and an empty frame; memory
// contents are not cleared. A stalled receiver holds the output register; the
// unit keeps taking words until the next result is ready, which then waits in
// the output state. A write to a configuration register restarts the frame.
// ---------------------------------------------------------------------------
module rgb_error_diffusion_dither_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
    output logic        m_axis_tlast,   // frame_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import red_pkg::*;
    `include "rgb_error_diffusion_dither_unit_macros.svh"

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int AW = $clog2(DEPTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = WW + HW;

    logic [10:0] r_width, r_height;
    logic [8:0]  r_levels;
    logic [CW-1:0] r_arrived, r_proc;
    logic [AW-1:0] r_wslot, r_pslot;
    logic [WW-1:0] r_x;
    logic [HW-1:0] r_y;
    t_state r_state, n_state;

    // effective configuration
    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;
    logic [7:0]    w_m;
    logic [CW-1:0] w_total;
    always_comb begin
        if (r_width == 11'd0) w_w = WW'(1);
        else if (32'(r_width) > MAX_WIDTH) w_w = WW'(MAX_WIDTH);
        else w_w = WW'(r_width);
        if (r_height == 11'd0) w_h = HW'(1);
        else if (32'(r_height) > MAX_HEIGHT) w_h = HW'(MAX_HEIGHT);
        else w_h = HW'(r_height);
        if (r_levels < 9'd2) w_m = 8'd1;
        else if (r_levels > 9'd256) w_m = 8'd255;
        else w_m = 8'(r_levels - 9'd1);
    end
    // pixels in the frame
    assign w_total = CW'(w_w) * CW'(w_h);

    // ring index helper
    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        return (a >= (AW+1)'(DEPTH)) ? AW'(a - (AW+1)'(DEPTH)) : a[AW-1:0];
    endfunction

    // pixel memory
    t_pix mem [DEPTH];
    logic          m_we;
    logic [AW-1:0] m_addr;
    t_pix          m_wd, m_rd;
    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_addr] <= m_wd;
        m_rd <= mem[m_addr];
    end

    logic s_fire, cfg_fire, w_drain, w_out_go;
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_drain = s_axis_tuser;
    // the output state hands its word over once the output register is free
    assign w_out_go = (r_state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

    // neighbour bookkeeping
    logic [3:0] r_en;                 // right, below-left, below, below-right
    logic [AW-1:0] w_nslot [4];
    always_comb begin
        w_nslot[0] = wrap({1'b0, r_pslot} + (AW+1)'(1));
        w_nslot[1] = wrap({1'b0, r_pslot} + (AW+1)'(w_w) - (AW+1)'(1));
        w_nslot[2] = wrap({1'b0, r_pslot} + (AW+1)'(w_w));
        w_nslot[3] = wrap({1'b0, r_pslot} + (AW+1)'(w_w) + (AW+1)'(1));
    end

    t_pix r_cur, r_nb [4];
    t_pix w_upd [4];
    logic signed [9:0] r_err [3];
    logic [7:0] r_q [3];
    logic [1:0] r_ch;
    logic q_start, q_done;
    logic [7:0] q_v, q_out;
    logic r_qbusy;
    logic r_cap3;
    logic [2:0] w_wt [4];
    assign w_wt[0] = 3'd7;
    assign w_wt[1] = 3'd3;
    assign w_wt[2] = 3'd5;
    assign w_wt[3] = 3'd1;

    // neighbours with the error added, written back in the WB states
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_upd[i].r = red_spread(r_nb[i].r, r_err[0], w_wt[i]);
            w_upd[i].g = red_spread(r_nb[i].g, r_err[1], w_wt[i]);
            w_upd[i].b = red_spread(r_nb[i].b, r_err[2], w_wt[i]);
        end
    end

    red_quant u_quant (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(q_start), .i_v(q_v),
        .i_m(w_m), .o_done(q_done), .o_q(q_out)
    );
    always_comb begin
        unique case (r_ch)
            2'd0:    q_v = r_cur.r;
            2'd1:    q_v = r_cur.g;
            default: q_v = r_cur.b;
        endcase
    end

    // process decision on the accepted word
    logic w_go;
    always_comb begin
        w_go = 1'b0;
        if (w_drain) w_go = (r_arrived >= w_total) && (r_proc < w_total);
        else w_go = (r_arrived < w_total) &&
                    ((r_arrived + CW'(1)) >= (r_proc + CW'(w_w) + CW'(2)));
    end

    // next state and memory port
    always_comb begin
        n_state = r_state;
        m_we = 1'b0;
        m_addr = r_pslot;
        m_wd = r_cur;
        q_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire && !w_drain && r_arrived < w_total) begin
                    m_we = 1'b1;
                    m_addr = r_wslot;
                    m_wd = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
                end
                if (s_fire && w_go) n_state = ST_RD0;
            end
            ST_RD0: begin m_addr = r_pslot;    n_state = ST_RD1; end
            ST_RD1: begin m_addr = w_nslot[0]; n_state = ST_RD2; end
            ST_RD2: begin m_addr = w_nslot[1]; n_state = ST_RD3; end
            ST_RD3: begin m_addr = w_nslot[2]; n_state = ST_QUANT; end
            ST_QUANT: begin
                m_addr = w_nslot[3];
                q_start = !r_qbusy;
                if (q_done && r_ch == 2'd2) n_state = ST_WB0;
            end
            ST_WB0: begin m_addr = w_nslot[0]; m_we = r_en[0]; m_wd = w_upd[0];
                n_state = ST_WB1; end
            ST_WB1: begin m_addr = w_nslot[1]; m_we = r_en[1]; m_wd = w_upd[1];
                n_state = ST_WB2; end
            ST_WB2: begin m_addr = w_nslot[2]; m_we = r_en[2]; m_wd = w_upd[2];
                n_state = ST_WB3; end
            ST_WB3: begin m_addr = w_nslot[3]; m_we = r_en[3]; m_wd = w_upd[3];
                n_state = ST_OUT; end
            ST_OUT: begin
                if (w_out_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd640; r_height <= 11'd480; r_levels <= 9'd2;
            r_arrived <= '0; r_proc <= '0; r_wslot <= '0; r_pslot <= '0;
            r_x <= '0; r_y <= '0; m_axis_tvalid <= 1'b0; r_qbusy <= 1'b0;
            r_ch <= '0;
        end else begin
            if (w_out_go) m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_LEVELS: r_levels <= i_cfg_data[8:0];
                    default: ;
                endcase
                if (i_cfg_index <= REG_LEVELS) begin
                    r_arrived <= '0; r_proc <= '0; r_wslot <= '0; r_pslot <= '0;
                    r_x <= '0; r_y <= '0;
                end
            end
            if (r_state == ST_IDLE && s_fire && !w_drain && r_arrived < w_total) begin
                r_arrived <= r_arrived + CW'(1);
                r_wslot <= wrap({1'b0, r_wslot} + (AW+1)'(1));
            end
            if (r_state == ST_RD0) begin
                r_en[0] <= (r_x + WW'(1)) < w_w;
                r_en[1] <= ((r_y + HW'(1)) < w_h) && (r_x != '0);
                r_en[2] <= (r_y + HW'(1)) < w_h;
                r_en[3] <= ((r_y + HW'(1)) < w_h) && ((r_x + WW'(1)) < w_w);
                r_ch <= '0;
            end
            if (r_state == ST_RD1) r_cur <= m_rd;
            if (r_state == ST_RD2) r_nb[0] <= m_rd;
            if (r_state == ST_RD3) r_nb[1] <= m_rd;
            if (r_state == ST_QUANT) begin
                if (r_ch == 2'd0 && !r_qbusy) r_nb[2] <= m_rd;
                if (q_start) r_qbusy <= 1'b1;
                if (q_done) begin
                    r_qbusy <= 1'b0;
                    r_q[r_ch] <= q_out;
                    r_err[r_ch] <= $signed({2'b00, q_v}) - $signed({2'b00, q_out});
                    r_ch <= r_ch + 2'd1;
                end
            end
            // the below-right neighbour arrives in the second quantizer cycle
            if (r_cap3) r_nb[3] <= m_rd;
            if (w_out_go) begin
                m_axis_tdata  <= {r_q[2], r_q[1], r_q[0]};
                m_axis_tlast  <= (r_proc + CW'(1)) == w_total;
                if ((r_proc + CW'(1)) >= w_total) begin
                    r_proc <= '0; r_arrived <= '0; r_wslot <= '0; r_pslot <= '0;
                    r_x <= '0; r_y <= '0;
                end else begin
                    r_proc <= r_proc + CW'(1);
                    r_pslot <= wrap({1'b0, r_pslot} + (AW+1)'(1));
                    if ((r_x + WW'(1)) == w_w) begin
                        r_x <= '0; r_y <= r_y + HW'(1);
                    end else r_x <= r_x + WW'(1);
                end
            end
        end
    end

    // the below-right neighbour is read during the first quantizer cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap3 <= 1'b0;
        else r_cap3 <= (r_state == ST_QUANT) && q_start && (r_ch == 2'd0);
    end

    `RED_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == ST_IDLE)
    `RED_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `RED_ASSERT_NXT(a_wb_out, i_clk, i_rst_n, r_state == ST_WB3, r_state == ST_OUT)
endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the RGB error diffusion dither unit
// Streams raster frames of random and extreme pixels through the unit under
// several frame sizes and level counts, predicts each dithered word and
// compares it with the m_axis output, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
    import red_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 1026;
    localparam int CAP_DIM    = 1024;

    typedef struct {
        bit       drain;
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
    } t_word_in;

    typedef struct {
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit       last;
    } t_word_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    rgb_error_diffusion_dither_unit i_dut (.*);

    // Words waiting for the driver, and dithered pixels still to come out.
    t_word_in  pixel_words[$];
    t_word_out dithered_q[$];

    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_start = 0;
    logic hold_rx;

    // Shadow copy of the unit: configuration, the pixel ring and both counts.
    int unsigned sh_width, sh_height, sh_levels;
    bit [7:0]    ring_ch [0:RING_DEPTH-1][0:2];
    int unsigned arrived_n, emitted_n;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int unsigned eff_w();
        if (sh_width == 0) return 1;
        return (sh_width > CAP_DIM) ? CAP_DIM : sh_width;
    endfunction

    function automatic int unsigned eff_h();
        if (sh_height == 0) return 1;
        return (sh_height > CAP_DIM) ? CAP_DIM : sh_height;
    endfunction

    function automatic int unsigned eff_steps();
        if (sh_levels < 2) return 1;
        return (sh_levels > 256) ? 255 : sh_levels - 1;
    endfunction

    function automatic bit [7:0] quant_level(bit [7:0] v, int unsigned m);
        int unsigned idx;
        idx = (v * m + 127) / 255;
        return 8'((idx * 255) / m);
    endfunction

    // Adds weight/16 of the error to one buffered neighbour, clamped.
    function automatic void diffuse(int unsigned pos, int e[3], int wt);
        int unsigned slot;
        int n;
        slot = pos % RING_DEPTH;
        for (int c = 0; c < 3; c++) begin
            n = int'(ring_ch[slot][c]) * 16 + wt * e[c];
            if (n < 0) n = 0;
            n = n / 16;
            if (n > 255) n = 255;
            ring_ch[slot][c] = n[7:0];
        end
    endfunction

    function automatic t_word_out dither_next();
        t_word_out o;
        int unsigned w, h, m, total, k, x, y, slot;
        int e[3];
        bit [7:0] q[3];
        w = eff_w();
        h = eff_h();
        m = eff_steps();
        total = w * h;
        k = emitted_n;
        x = k % w;
        y = k / w;
        slot = k % RING_DEPTH;
        for (int c = 0; c < 3; c++) begin
            q[c] = quant_level(ring_ch[slot][c], m);
            e[c] = int'(ring_ch[slot][c]) - int'(q[c]);
        end
        o.r = q[0];
        o.g = q[1];
        o.b = q[2];
        o.last = (k + 1 == total);
        if (x + 1 < w) diffuse(k + 1, e, 7);
        if (y + 1 < h) begin
            if (x >= 1) diffuse(k + w - 1, e, 3);
            diffuse(k + w, e, 5);
            if (x + 1 < w) diffuse(k + w + 1, e, 1);
        end
        emitted_n = k + 1;
        if (emitted_n >= total) begin
            emitted_n = 0;
            arrived_n = 0;
        end
        return o;
    endfunction

    // Queues one word for the driver and records the pixel it must yield, if any.
    task automatic push_word(bit drain, bit [7:0] r, bit [7:0] g, bit [7:0] b);
        t_word_in wi;
        int unsigned total, slot;
        wi.drain = drain;
        wi.r = r;
        wi.g = g;
        wi.b = b;
        pixel_words.push_back(wi);
        total = eff_w() * eff_h();
        if (drain) begin
            if (arrived_n >= total && emitted_n < total)
                dithered_q.push_back(dither_next());
        end else if (arrived_n < total) begin
            slot = arrived_n % RING_DEPTH;
            ring_ch[slot][0] = r;
            ring_ch[slot][1] = g;
            ring_ch[slot][2] = b;
            arrived_n++;
            if (arrived_n >= emitted_n + eff_w() + 2)
                dithered_q.push_back(dither_next());
        end
    endtask

    function automatic bit [7:0] pick_chan();
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Feeds one whole frame, with occasional ignored words mixed in.
    task automatic run_frame(int noise_pct);
        int unsigned total;
        total = eff_w() * eff_h();
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_word(1'b1, pick_chan(), pick_chan(), pick_chan());
            push_word(1'b0, pick_chan(), pick_chan(), pick_chan());
        end
        while (arrived_n != 0) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_word(1'b0, pick_chan(), pick_chan(), pick_chan());
            push_word(1'b1, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    // Register writes happen only with the unit idle, so the shadow copy
    // can be updated right here.
    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH:  sh_width  = val;
            REG_HEIGHT: sh_height = val;
            default:    sh_levels = val[8:0];
        endcase
        arrived_n = 0;
        emitted_n = 0;
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [10:0] lv);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LEVELS, lv);
    endtask

    // Waits until every word is in and every pixel is out, then lets the
    // longest latency of the unit pass before anything else happens.
    task automatic wait_idle();
        while (pixel_words.size() != 0 || s_axis_tvalid || dithered_q.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what);
        $display("tb: mismatch: %s", what);
        err_count++;
    endtask

    // Driver: a new word goes out once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_word_in wi;
                wi = pixel_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= wi.drain;
                s_axis_tdata  <= {wi.b, wi.g, wi.r};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each taken word with the oldest predicted pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (dithered_q.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                t_word_out ex;
                ex = dithered_q.pop_front();
                if (m_axis_tdata[7:0] !== ex.r)
                    report_mismatch($sformatf("red %0d, want %0d", m_axis_tdata[7:0], ex.r));
                if (m_axis_tdata[15:8] !== ex.g)
                    report_mismatch($sformatf("green %0d, want %0d",
                                              m_axis_tdata[15:8], ex.g));
                if (m_axis_tdata[23:16] !== ex.b)
                    report_mismatch($sformatf("blue %0d, want %0d",
                                              m_axis_tdata[23:16], ex.b));
                if (m_axis_tlast !== ex.last)
                    report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, ex.last));
            end
        end
        m_axis_tready <= i_rst_n && !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Long receiver stall while the sender keeps offering pixels.
    initial begin
        hold_rx = 1'b0;
        wait (hold_start);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (700) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        int random_words;
        int phase_words;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        sh_width  = 640;
        sh_height = 480;
        sh_levels = 2;
        arrived_n = 0;
        emitted_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a small frame with extreme pixels, plus a drain before
        // the frame is in and a pixel after it, both of which are ignored.
        set_frame(11'd3, 11'd2, 11'd2);
        push_word(1'b1, 8'h00, 8'h00, 8'h00);
        push_word(1'b0, 8'hFF, 8'h00, 8'h80);
        push_word(1'b0, 8'h00, 8'hFF, 8'h7F);
        push_word(1'b0, 8'h80, 8'h80, 8'hFF);
        push_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        push_word(1'b0, 8'h00, 8'h00, 8'h00);
        push_word(1'b0, 8'h7F, 8'h81, 8'h01);
        push_word(1'b0, 8'h55, 8'hAA, 8'h55);
        while (arrived_n != 0) push_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // Zero sizes act as one pixel, too few levels act as two.
        set_frame(11'd0, 11'd0, 11'd0);
        push_word(1'b0, 8'h80, 8'h7F, 8'hFF);
        push_word(1'b1, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Too many levels act as the full 256.
        set_frame(11'd2, 11'd2, 11'h7FF);
        run_frame(0);
        wait_idle();
        set_frame(11'd2, 11'd3, 11'd256);
        run_frame(0);
        wait_idle();

        // Widest and tallest settings, clamped to the maximum; only the
        // start of each frame is sent before the next write restarts it.
        set_frame(11'h7FF, 11'd1, 11'd3);
        for (int i = 0; i < 40; i++) push_word(1'b0, pick_chan(), pick_chan(), pick_chan());
        wait_idle();
        set_frame(11'd1, 11'h7FF, 11'd5);
        for (int i = 0; i < 40; i++) push_word(1'b0, pick_chan(), pick_chan(), pick_chan());
        wait_idle();

        // Random phases of small frames; the idle pattern moves through
        // three stages as the word count grows.
        random_words = 0;
        hold_start = 1'b1;
        while (random_words < 1640) begin
            case (random_words * 3 / 1640)
                0: begin send_idle_pct = 22; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)),
                      ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 511))
                                                  : 11'($urandom_range(2, 16)));
            phase_words = pixel_words.size();
            repeat ($urandom_range(1, 3)) run_frame(5);
            random_words += pixel_words.size() - phase_words;
            wait_idle();
        end

        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

@@ rgb_error_diffusion_dither_unit.f @@
+incdir+hw/rtl
hw/rtl/red_pkg.sv
hw/rtl/red_quant.sv
hw/rtl/rgb_error_diffusion_dither_unit.sv
bench/tb.sv
